/* hdl/soft_tlb_fill_and_invalidate_defines.svh */
// Assertion macros for the translation buffer checker.
`ifndef SOFT_TLB_FILL_AND_INVALIDATE_DEFINES_SVH
`define SOFT_TLB_FILL_AND_INVALIDATE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define STLB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define STLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/stlb_pkg.sv */
// Package with operation codes, register indexes and channel layout of the translation buffer.
`timescale 1ns / 1ps
package stlb_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_FILL       = 2'd0;
    localparam op_t OP_FLUSH_ALL  = 2'd1;
    localparam op_t OP_FLUSH_PAGE = 2'd2;
    localparam op_t OP_QUERY      = 2'd3;

    localparam logic REG_DISABLE_FLUSH = 1'b0;
    localparam logic REG_TRACE_ENABLE  = 1'b1;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 40;

endpackage

/* hdl/soft_tlb_fill_and_invalidate.sv */
// Top level of the direct-mapped translation buffer with fill, flush and dirty query.
`timescale 1ns / 1ps
// Direct-mapped translation buffer, one table per MMU mode, all modes of one index in one row.
// Input channel s_axis: one item per operation (fill page, flush all, flush page, query dirty).
// Output channel m_axis: exactly one result item for every input item, in order.
// Configuration: cfg_we/cfg_addr/cfg_wdata; the user must write them only while the block is
// idle, as the block does not enforce it. An item is accepted in the idle state, its row is
// read from the RAM in that cycle and the result is registered in the execute state once the
// result register is free; the single read-modify-write of the row RAM happens there too.
// A fill of a large page into an existing region then passes the walk state, where the region
// mask moves one bit a cycle until the region covers the page.
// Full flushes clear the valid bit of every row at once, with no sweep of the RAM.
// Reset: all rows invalid, region empty, flush count zero, both registers zero. No sweep runs.
// Stall: the result register holds its item until m_axis_tready; a following item may then
// complete its read but waits for the register before writing its row back.
// ENTRIES must be a power of two.
module soft_tlb_fill_and_invalidate
    import stlb_pkg::*;
#(
    parameter int MODES     = 4,
    parameter int ENTRIES   = 256,
    parameter int PAGE_BITS = 12,
    parameter int ADDR_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // operation, vaddr, mmu_mode, prot_read, prot_write, prot_exec, size_log2,
    // is_ram, page_dirty, watch_trap, host_addend, io_entry
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // full_flush, modes_cleared, all_dirty, flush_count, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic                   cfg_addr,
    input  logic                   cfg_wdata
);

    localparam int VPN_W = ADDR_BITS - PAGE_BITS;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int ENT_W = VPN_W + 4;
    localparam int ROW_W = MODES * ENT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    localparam logic [ADDR_BITS-1:0] AMASK = {ADDR_BITS{1'b1}};

    logic [1:0]           state_reg, state_next;
    logic                 disable_reg, trace_reg;
    logic [ENTRIES-1:0]   valid_reg;
    logic [ADDR_BITS-1:0] base_reg, mask_reg, walk_reg;
    logic [31:0]          count_reg;
    logic                 out_valid_reg;
    logic [36:0]          out_reg;

    // Item captured at acceptance.
    op_t                  op_reg;
    logic [ADDR_BITS-1:0] vraw_reg;
    logic [1:0]           mode_reg;
    logic                 pr_reg, pw_reg, px_reg, ram_reg, dirty_reg, watch_reg;
    logic [5:0]           size_reg;

    logic [ROW_W-1:0]     rdata, row_cur, row_new;
    logic [VPN_W-1:0]     vpn;
    logic [IDX_W-1:0]     idx;
    logic                 hit, flush_do, exec_go, ram_we, dirty_all, wclean;
    logic [3:0]           cleared;
    logic [ADDR_BITS-1:0] large_mask;
    logic                 accept;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg};

    assign vpn = vraw_reg[ADDR_BITS-1:PAGE_BITS];
    assign idx = vpn[IDX_W-1:0];

    stlb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (row_new),
        .re    (accept),
        .raddr (s_axis_tdata[2+PAGE_BITS +: IDX_W]),
        .rdata (rdata)
    );

    assign exec_go  = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);
    assign hit      = ((vraw_reg & mask_reg) == base_reg);
    assign flush_do = !disable_reg &&
                      ((op_reg == OP_FLUSH_ALL) || ((op_reg == OP_FLUSH_PAGE) && hit));
    assign wclean   = pw_reg && ram_reg && dirty_reg && !watch_reg && !trace_reg;
    assign large_mask = (size_reg >= 6'(ADDR_BITS)) ? '0 : (AMASK << size_reg);

    always_comb
    begin
        logic [ENT_W-1:0] ent;
        logic             match;
        row_cur   = valid_reg[idx] ? rdata : '0;
        row_new   = row_cur;
        cleared   = '0;
        dirty_all = 1'b1;
        for (int m = 0; m < MODES; m++)
        begin
            ent   = row_cur[m*ENT_W +: ENT_W];
            match = (ent[0] || ent[1] || ent[2]) && (ent[ENT_W-1:4] == vpn);
            if (!(ent[1] && ent[3] && (ent[ENT_W-1:4] == vpn)))
            begin
                dirty_all = 1'b0;
            end
            case (op_reg)
                OP_FILL:
                begin
                    if (int'(mode_reg) == m)
                    begin
                        row_new[m*ENT_W +: ENT_W] = {vpn, wclean, px_reg, pw_reg, pr_reg};
                    end
                end
                OP_FLUSH_PAGE:
                begin
                    if (match)
                    begin
                        row_new[m*ENT_W +: ENT_W] = {ent[ENT_W-1:4], 4'b0000};
                        cleared = cleared + 4'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign ram_we = exec_go &&
                    (((op_reg == OP_FILL) && (int'(mode_reg) < MODES)) ||
                     ((op_reg == OP_FLUSH_PAGE) && !hit));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    if ((op_reg == OP_FILL) && (int'(mode_reg) < MODES) &&
                        (size_reg > 6'(PAGE_BITS)) && (base_reg != AMASK))
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WALK:
            begin
                if (((base_reg ^ vraw_reg) & walk_reg) == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            disable_reg   <= 1'b0;
            trace_reg     <= 1'b0;
            valid_reg     <= '0;
            base_reg      <= AMASK;
            mask_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_DISABLE_FLUSH: disable_reg <= cfg_wdata;
                    REG_TRACE_ENABLE:  trace_reg   <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (m_axis_tready && !exec_go)
            begin
                out_valid_reg <= 1'b0;
            end
            if (exec_go)
            begin
                out_valid_reg <= 1'b1;
                if (ram_we)
                begin
                    valid_reg[idx] <= 1'b1;
                end
                if (flush_do)
                begin
                    valid_reg <= '0;
                    base_reg  <= AMASK;
                    mask_reg  <= '0;
                    count_reg <= count_reg + 32'd1;
                end
                // The first large page defines the region outright.
                if ((op_reg == OP_FILL) && (int'(mode_reg) < MODES) &&
                    (size_reg > 6'(PAGE_BITS)) && (base_reg == AMASK))
                begin
                    base_reg <= vraw_reg & large_mask;
                    mask_reg <= large_mask;
                end
            end
            if ((state_reg == ST_WALK) && (((base_reg ^ vraw_reg) & walk_reg) == '0))
            begin
                base_reg <= base_reg & walk_reg;
                mask_reg <= walk_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= s_axis_tdata[1:0];
            vraw_reg  <= ADDR_BITS'(s_axis_tdata[33:2]);
            mode_reg  <= s_axis_tdata[35:34];
            pr_reg    <= s_axis_tdata[36];
            pw_reg    <= s_axis_tdata[37];
            px_reg    <= s_axis_tdata[38];
            size_reg  <= s_axis_tdata[44:39];
            ram_reg   <= s_axis_tdata[45];
            dirty_reg <= s_axis_tdata[46];
            watch_reg <= s_axis_tdata[47];
        end
        if (exec_go)
        begin
            walk_reg <= large_mask & mask_reg;
            out_reg  <= {(flush_do ? count_reg + 32'd1 : count_reg),
                         (op_reg == OP_QUERY) && dirty_all,
                         ((op_reg == OP_FLUSH_PAGE) && !hit) ? cleared[2:0] : 3'd0,
                         (op_reg == OP_FLUSH_PAGE) && hit};
        end
        else if (state_reg == ST_WALK)
        begin
            walk_reg <= walk_reg << 1;
        end
    end

endmodule

/* hdl/stlb_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module stlb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/stlb_checker.sv */
// Port-level checker for the translation buffer and its bind statement.
`timescale 1ns / 1ps
`include "soft_tlb_fill_and_invalidate_defines.svh"
module stlb_checker
    import stlb_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result item must not change.
    `STLB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result item changed while stalled")
    // Once an item is taken, the block stops accepting input while it works on that item.
    `STLB_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken on consecutive cycles")
    // A new result appears only after the block has stopped accepting input to work on its item.
    `STLB_ASSERT_IMPL(a_result_after_work, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared without execution cycle")

endmodule

bind soft_tlb_fill_and_invalidate stlb_checker u_stlb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/tb_top.sv */
// Self-checking testbench for the translation buffer: fills, flushes and dirty queries.
`timescale 1ns / 1ps
module tb_top;
    import stlb_pkg::*;

    typedef struct {
        op_t         op;
        logic [31:0] vaddr;
        logic [1:0]  mode;
        logic        prot_r;
        logic        prot_w;
        logic        prot_x;
        logic [5:0]  size_log2;
        logic        is_ram;
        logic        page_dirty;
        logic        watch_trap;
        logic [47:0] host_addend;
        logic [47:0] io_entry;
    } tlb_req_t;

    typedef struct {
        logic        full_flush;
        logic [2:0]  modes_cleared;
        logic        all_dirty;
        logic [31:0] flush_count;
    } tlb_resp_t;

    localparam int          NUM_MODES = 4;
    localparam logic [31:0] PAGE_MASK = 32'hFFFF_F000;
    localparam logic [31:0] FLAG_INV  = 32'h0000_0008;
    localparam logic [31:0] FLAG_ND   = 32'h0000_0010;
    localparam logic [31:0] FLAG_MMIO = 32'h0000_0020;
    localparam logic [31:0] FLAG_SYMB = 32'h0000_0040;
    localparam logic [31:0] FLAG_TRC  = 32'h0000_0080;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic                   cfg_addr;
    logic                   cfg_wdata;

    // Shadow copy of the tables and registers.
    logic [31:0] rd_tag [NUM_MODES][256];
    logic [31:0] wr_tag [NUM_MODES][256];
    logic [31:0] cd_tag [NUM_MODES][256];
    logic [31:0] region_base;
    logic [31:0] region_mask;
    logic [31:0] flush_total;
    logic        flush_off;
    logic        trace_on;

    tlb_resp_t pending_resp[$];
    int        mismatches;
    bit        quiet;
    bit        long_hold_req;
    int        rdy_stall;

    soft_tlb_fill_and_invalidate u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [IN_TDATA_W-1:0] pack_req(tlb_req_t r);
        return {r.io_entry, r.host_addend, r.watch_trap, r.page_dirty, r.is_ram, r.size_log2,
                r.prot_x, r.prot_w, r.prot_r, r.mode, r.vaddr, r.op};
    endfunction

    function automatic void tlb_full_flush();
        if (flush_off)
            return;
        for (int m = 0; m < NUM_MODES; m++)
            for (int i = 0; i < 256; i++)
            begin
                rd_tag[m][i] = '1;
                wr_tag[m][i] = '1;
                cd_tag[m][i] = '1;
            end
        region_base = '1;
        region_mask = '0;
        flush_total = flush_total + 32'd1;
    endfunction

    function automatic void grow_region(logic [31:0] va, int unsigned s);
        logic [63:0] wide;
        logic [31:0] mask;
        wide = (64'd1 << s) - 64'd1;
        mask = (s >= 32) ? 32'd0 : ~wide[31:0];
        if (region_base == '1)
        begin
            region_base = va & mask;
            region_mask = mask;
            return;
        end
        mask &= region_mask;
        while (((region_base ^ va) & mask) != 0)
            mask = mask << 1;
        region_base &= mask;
        region_mask = mask;
    endfunction

    // Updates the shadow tables for one accepted item and returns its result.
    function automatic tlb_resp_t tlb_predict(logic [IN_TDATA_W-1:0] d);
        tlb_resp_t   res;
        tlb_req_t    r;
        logic [31:0] va;
        logic [31:0] addr;
        logic [31:0] code;
        logic [31:0] km;
        int          idx;
        r.op = d[1:0];
        r.vaddr = d[33:2];
        r.mode = d[35:34];
        r.prot_r = d[36];
        r.prot_w = d[37];
        r.prot_x = d[38];
        r.size_log2 = d[44:39];
        r.is_ram = d[45];
        r.page_dirty = d[46];
        r.watch_trap = d[47];
        res = '{1'b0, 3'd0, 1'b0, 32'd0};
        va = r.vaddr & PAGE_MASK;
        idx = int'(va[19:12]);
        case (r.op)
            OP_FILL:
            begin
                if (r.size_log2 > 6'd12)
                    grow_region(va, 32'(r.size_log2));
                addr = va;
                if (!r.is_ram)
                    addr |= FLAG_MMIO;
                code = addr;
                if (r.watch_trap)
                    addr |= FLAG_MMIO;
                rd_tag[r.mode][idx] = r.prot_r ? addr : '1;
                cd_tag[r.mode][idx] = r.prot_x ? code : '1;
                if (!r.prot_w)
                    wr_tag[r.mode][idx] = '1;
                else if (!r.is_ram)
                    wr_tag[r.mode][idx] = addr | FLAG_MMIO;
                else
                    wr_tag[r.mode][idx] = r.page_dirty ? addr : (addr | FLAG_ND);
                if (trace_on)
                begin
                    rd_tag[r.mode][idx] |= FLAG_TRC;
                    wr_tag[r.mode][idx] |= FLAG_TRC;
                end
            end
            OP_FLUSH_ALL:
                tlb_full_flush();
            OP_FLUSH_PAGE:
            begin
                // The region test uses the address before alignment.
                if ((r.vaddr & region_mask) == region_base)
                begin
                    res.full_flush = 1'b1;
                    tlb_full_flush();
                end
                else
                begin
                    km = PAGE_MASK | FLAG_INV;
                    for (int m = 0; m < NUM_MODES; m++)
                        if (va == (rd_tag[m][idx] & km) || va == (wr_tag[m][idx] & km) ||
                            va == (cd_tag[m][idx] & km))
                        begin
                            rd_tag[m][idx] = '1;
                            wr_tag[m][idx] = '1;
                            cd_tag[m][idx] = '1;
                            res.modes_cleared++;
                        end
                end
            end
            default:
            begin
                res.all_dirty = 1'b1;
                for (int m = 0; m < NUM_MODES; m++)
                    if ((wr_tag[m][idx] & ~FLAG_SYMB) != va)
                        res.all_dirty = 1'b0;
            end
        endcase
        res.flush_count = flush_total;
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            pending_resp.push_back(tlb_predict(s_axis_tdata));
    end

    always @(posedge clk)
    begin
        tlb_resp_t want;
        tlb_resp_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.full_flush = m_axis_tdata[0];
            got.modes_cleared = m_axis_tdata[3:1];
            got.all_dirty = m_axis_tdata[4];
            got.flush_count = m_axis_tdata[36:5];
            if (pending_resp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result item %h", m_axis_tdata);
            end
            else
            begin
                want = pending_resp.pop_front();
                if (got.full_flush !== want.full_flush
                    || got.modes_cleared !== want.modes_cleared
                    || got.all_dirty !== want.all_dirty
                    || got.flush_count !== want.flush_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected ff=%0d mc=%0d dirty=%0d cnt=%0d, ",
                                  "got ff=%0d mc=%0d dirty=%0d cnt=%0d"},
                                 want.full_flush, want.modes_cleared, want.all_dirty,
                                 want.flush_count, got.full_flush, got.modes_cleared,
                                 got.all_dirty, got.flush_count);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (rdy_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                rdy_stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rdy_stall = pick_gap();
            end
        end
    end

    task automatic send_item(tlb_req_t r);
        int gap;
        s_axis_tdata <= pack_req(r);
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits for every result and for the block to finish any region update.
    task automatic wait_drained();
        while (pending_resp.size() != 0)
            @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic val);
        idle_sender();
        wait_drained();
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DISABLE_FLUSH)
            flush_off = val;
        else
            trace_on = val;
    endtask

    function automatic logic [31:0] pool_page();
        logic [31:0] va;
        va = $urandom_range(0, 15) * 32'h0100_1000;
        // Occasionally the same row under a different tag.
        if ($urandom_range(0, 7) == 0)
            va ^= 32'h4000_0000;
        return va | $urandom_range(0, 4095);
    endfunction

    function automatic tlb_req_t noise_req();
        tlb_req_t r;
        r.op = op_t'($urandom_range(0, 3));
        r.vaddr = $urandom;
        r.mode = 2'($urandom_range(0, 3));
        r.prot_r = 1'($urandom_range(0, 1));
        r.prot_w = 1'($urandom_range(0, 1));
        r.prot_x = 1'($urandom_range(0, 1));
        r.size_log2 = 6'($urandom_range(0, 63));
        r.is_ram = 1'($urandom_range(0, 1));
        r.page_dirty = 1'($urandom_range(0, 1));
        r.watch_trap = 1'($urandom_range(0, 1));
        r.host_addend = 48'({$urandom, $urandom});
        r.io_entry = 48'({$urandom, $urandom});
        return r;
    endfunction

    function automatic tlb_req_t plain_fill(logic [31:0] va, logic [1:0] mode);
        tlb_req_t r;
        r = noise_req();
        r.op = OP_FILL;
        r.vaddr = va;
        r.mode = mode;
        r.prot_r = 1'b1;
        r.prot_w = 1'b1;
        r.is_ram = 1'b1;
        r.page_dirty = 1'b1;
        r.watch_trap = 1'b0;
        r.size_log2 = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(13, 32)) : 6'd12;
        return r;
    endfunction

    function automatic tlb_req_t page_op(op_t op, logic [31:0] va);
        tlb_req_t r;
        r = noise_req();
        r.op = op;
        r.vaddr = va;
        return r;
    endfunction

    task automatic test_directed();
        tlb_req_t r;
        // Query on an empty table, then a page filled in every mode.
        send_item(page_op(OP_QUERY, 32'h0000_5000));
        for (int m = 0; m < NUM_MODES; m++)
        begin
            r = plain_fill(32'h0000_5ABC, 2'(m));
            r.size_log2 = 6'd12;
            send_item(r);
        end
        send_item(page_op(OP_QUERY, 32'h0000_5FFF));
        send_item(page_op(OP_FLUSH_PAGE, 32'h0000_5123));
        send_item(page_op(OP_QUERY, 32'h0000_5000));
        // MMIO, watch trap, no rights, extreme data.
        r = plain_fill(32'hFFFF_FFFF, 2'd3);
        r.is_ram = 1'b0;
        r.watch_trap = 1'b1;
        r.prot_x = 1'b1;
        r.host_addend = '1;
        r.io_entry = '1;
        r.size_log2 = 6'd12;
        send_item(r);
        r = plain_fill(32'h0000_0000, 2'd0);
        r.prot_r = 1'b0;
        r.prot_w = 1'b0;
        r.prot_x = 1'b0;
        r.page_dirty = 1'b0;
        r.host_addend = '0;
        r.io_entry = '0;
        r.size_log2 = 6'd0;
        send_item(r);
        r = plain_fill(32'h0000_0000, 2'd1);
        r.page_dirty = 1'b0;
        r.size_log2 = 6'd12;
        send_item(r);
        send_item(page_op(OP_FLUSH_PAGE, 32'hFFFF_F000));
        send_item(page_op(OP_FLUSH_PAGE, 32'h0000_0000));
        // Large pages: grow the region, then hit it.
        r = plain_fill(32'h1234_5678, 2'd2);
        r.size_log2 = 6'd16;
        send_item(r);
        r = plain_fill(32'h1238_0000, 2'd1);
        r.size_log2 = 6'd13;
        send_item(r);
        send_item(page_op(OP_FLUSH_PAGE, 32'h1230_0FFF));
        r = plain_fill(32'h8000_0000, 2'd0);
        r.size_log2 = 6'd32;
        send_item(r);
        send_item(page_op(OP_FLUSH_PAGE, 32'h0000_0001));
        r = plain_fill(32'h0000_7000, 2'd0);
        r.size_log2 = 6'd63;
        send_item(r);
        send_item(page_op(OP_FLUSH_ALL, 32'h0));
        send_item(page_op(OP_FLUSH_PAGE, 32'hFFFF_FFFF));
    endtask

    task automatic test_flush_disabled_and_trace();
        tlb_req_t r;
        write_reg(REG_DISABLE_FLUSH, 1'b1);
        write_reg(REG_TRACE_ENABLE, 1'b1);
        r = plain_fill(32'h0040_0000, 2'd0);
        r.size_log2 = 6'd20;
        send_item(r);
        send_item(page_op(OP_FLUSH_PAGE, 32'h0040_0000));
        send_item(page_op(OP_FLUSH_ALL, 32'h0));
        send_item(page_op(OP_QUERY, 32'h0040_0000));
        write_reg(REG_DISABLE_FLUSH, 1'b0);
        send_item(page_op(OP_FLUSH_PAGE, 32'h0040_0000));
        write_reg(REG_TRACE_ENABLE, 1'b0);
    endtask

    task automatic test_random(int count);
        tlb_req_t    r;
        logic [31:0] va;
        int          n;
        int          kind;
        n = 0;
        while (n < count)
        begin
            kind = $urandom_range(0, 99);
            va = pool_page();
            if (kind < 35)
            begin
                // A page mapped in every mode, then a query or a page flush.
                for (int m = 0; m < NUM_MODES; m++)
                begin
                    r = plain_fill(va, 2'(m));
                    if ($urandom_range(0, 9) == 0)
                        r.page_dirty = 1'b0;
                    send_item(r);
                end
                send_item(page_op($urandom_range(0, 1) ? OP_QUERY : OP_FLUSH_PAGE, va));
                n += 5;
            end
            else if (kind < 75)
            begin
                r = ($urandom_range(0, 1)) ? plain_fill(va, 2'($urandom_range(0, 3)))
                                           : page_op(op_t'($urandom_range(2, 3)), va);
                if (r.op == OP_FILL && $urandom_range(0, 3) == 0)
                    r = noise_req();
                r.vaddr = va;
                send_item(r);
                n++;
            end
            else
            begin
                r = noise_req();
                if (r.op == OP_FLUSH_ALL && $urandom_range(0, 3) != 0)
                    r.op = OP_QUERY;
                send_item(r);
                n++;
            end
        end
    endtask

    task automatic test_config_sweep();
        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_DISABLE_FLUSH, p[0]);
            write_reg(REG_TRACE_ENABLE, p[1]);
            quiet = (p == 2);
            test_random(385);
        end
        quiet = 1'b0;
        write_reg(REG_DISABLE_FLUSH, 1'b0);
        write_reg(REG_TRACE_ENABLE, 1'b0);
    endtask

    task automatic test_backpressure();
        wait_drained();
        long_hold_req = 1'b1;
        quiet = 1'b1;
        test_random(30);
        quiet = 1'b0;
        // Sender pauses until everything has come back, then carries on.
        idle_sender();
        wait_drained();
        test_random(40);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_wdata = 1'b0;
        mismatches = 0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        rdy_stall = 0;
        flush_off = 1'b0;
        trace_on = 1'b0;
        flush_total = '0;
        region_base = '1;
        region_mask = '0;
        for (int m = 0; m < NUM_MODES; m++)
            for (int i = 0; i < 256; i++)
            begin
                rd_tag[m][i] = '1;
                wr_tag[m][i] = '1;
                cd_tag[m][i] = '1;
            end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_flush_disabled_and_trace();
        test_config_sweep();
        test_backpressure();
        idle_sender();
        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/stlb_pkg.sv
hdl/stlb_ram.sv
hdl/soft_tlb_fill_and_invalidate.sv
hdl/stlb_checker.sv
bench/tb_top.sv
